[src/sbbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbbs_pkg
// Shared types and constants of the spectrum bar binning and smoothing block:
// transaction payloads, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package sbbs_pkg;

  // Field widths
  localparam int MAG_W      = 16;
  localparam int BAR_W      = 6;
  localparam int GAIN_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default sizes
  localparam int MAX_BARS_DEF         = 64;
  localparam int MAX_BINS_PER_BAR_DEF = 512;

  // Unity gain in Q1.8
  localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_CHANNELS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LEVELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY     = 3'd6;

  // Register reset values
  localparam logic              RST_MIX_CHANNELS   = 1'b1;
  localparam logic              RST_AVERAGE_LEVELS = 1'b0;
  localparam logic [MAG_W-1:0]  RST_MIN_LEVEL      = 16'd0;
  localparam logic [MAG_W-1:0]  RST_MAX_LEVEL      = 16'd13107;
  localparam logic [GAIN_W-1:0] RST_RISE_GAIN      = 9'd128;
  localparam logic [GAIN_W-1:0] RST_FALL_GAIN      = 9'd128;
  localparam logic [MAG_W-1:0]  RST_PEAK_DECAY     = 16'd32768;

  // Input transaction
  typedef struct packed {
    logic [MAG_W-1:0] left_mag;
    logic [MAG_W-1:0] right_mag;
    logic [BAR_W-1:0] bar_number;
    logic             last_in_bar;
  } sbbs_in_t;

  // Result transaction
  typedef struct packed {
    logic [BAR_W-1:0] bar_out;
    logic [MAG_W-1:0] level_ch0;
    logic [MAG_W-1:0] peak_ch0;
    logic [MAG_W-1:0] level_ch1;
    logic [MAG_W-1:0] peak_ch1;
  } sbbs_out_t;

  // One memory row: both channels of one bar
  typedef struct packed {
    logic [MAG_W-1:0] level_ch0;
    logic [MAG_W-1:0] peak_ch0;
    logic [MAG_W-1:0] level_ch1;
    logic [MAG_W-1:0] peak_ch1;
  } sbbs_entry_t;

endpackage

[src/spectrum_bar_binning_smoothing_top.sv]
// ----------------------------------------------------------------------------
// spectrum_bar_binning_smoothing_top
// Folds FFT bin pairs into bars, then smooths and peak-holds each bar level.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one FFT bin pair per transaction, tagged with its bar number;
//            last_in_bar closes the bar.
//   out_*  : one transaction per closed bar (bars not below MAX_BARS report
//            nothing): smoothed level and peak of both channels.
//   cfg_*  : register writes (index, data), always ready; write only while
//            the block is idle.
// Timing:
//   A bin that does not close a bar leaves the block idle; the next one may
//   follow in the next cycle. A closing bin passes through memory read,
//   update and write back before the next bin is taken. In average mode
//   the bit-serial divider runs before the memory read. The result is
//   registered at write back, once the output register is free.
// Reset clears the registers to their defaults, the accumulators, and the
//   per-bar valid bits, so every stored level and peak reads as zero.
// A stalled receiver holds the result in the output register; bins keep
//   being accepted, and a closing bin waits at write back until it is free.
// ----------------------------------------------------------------------------
module spectrum_bar_binning_smoothing_top #(
  parameter int MAX_BARS         = sbbs_pkg::MAX_BARS_DEF,
  parameter int MAX_BINS_PER_BAR = sbbs_pkg::MAX_BINS_PER_BAR_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sbbs_pkg::sbbs_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sbbs_pkg::sbbs_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAG_W  = sbbs_pkg::MAG_W;
  localparam int GAIN_W = sbbs_pkg::GAIN_W;
  localparam int CNT_W  = $clog2(MAX_BINS_PER_BAR + 1);
  localparam int DEN_W  = CNT_W + 1;
  localparam int ACC_W  = MAG_W + 1 + CNT_W;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int BAR_AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int ROW_W  = $bits(sbbs_pkg::sbbs_entry_t);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_CALC = 5'b01000,
    ST_WB   = 5'b10000
  } state_t;

  // Registers
  logic                         mix_r, avg_r;
  logic [MAG_W-1:0]             min_r, max_r, decay_r;
  logic [GAIN_W-1:0]            rise_r, fall_r;

  // Bar accumulation state
  state_t                       state_r, state_nxt;
  logic [ACC_W-1:0]             acc0_r, acc0_nxt, acc1_r, acc1_nxt;
  logic [CNT_W-1:0]             bins_r, bins_nxt;
  logic [ACC_W-1:0]             v0_r, v0_nxt, v1_r, v1_nxt;
  logic [sbbs_pkg::BAR_W-1:0]   bar_r, bar_nxt;
  logic [BAR_AW-1:0]            bar_idx_r, bar_idx_nxt;
  logic [MAX_BARS-1:0]          row_valid_r;

  // Update pipeline
  logic [MAG_W-1:0]             s_r [2];
  logic [MAG_W-1:0]             p_r [2];
  logic                         up_r [2];
  logic [PROD_W-1:0]            prod_r [2];

  // Output register
  logic                         out_valid_r;
  sbbs_pkg::sbbs_out_t          out_data_r;

  // Combinational
  logic                         in_fire, bins_ok, bar_ok, out_free;
  logic [ACC_W-1:0]             l_ext, r_ext, mix_max, acc0_f, acc1_f;
  logic [CNT_W-1:0]             bins_f;
  logic [ACC_W-1:0]             num0, num1;
  logic [DEN_W-1:0]             divisor;
  logic                         div_start, div_done;
  logic [ACC_W-1:0]             quo0, quo1;
  logic                         rd_en, wr_en;
  logic [ROW_W-1:0]             rd_data;
  sbbs_pkg::sbbs_entry_t        row_cur, row_new;
  logic [ACC_W-1:0]             v_cur   [2];
  logic [MAG_W-1:0]             s_cur   [2];
  logic [MAG_W-1:0]             p_cur   [2];
  logic [MAG_W-1:0]             v_clamp [2];
  logic [MAG_W-1:0]             v_lvl   [2];
  logic                         up_cur  [2];
  logic [MAG_W-1:0]             diff    [2];
  logic [GAIN_W-1:0]            gain    [2];
  logic [GAIN_W-1:0]            rise_clip, fall_clip;
  logic [MAG_W-1:0]             step    [2];
  logic [MAG_W-1:0]             s_new   [2];
  logic [MAG_W-1:0]             p_new   [2];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r   <= sbbs_pkg::RST_MIX_CHANNELS;
      avg_r   <= sbbs_pkg::RST_AVERAGE_LEVELS;
      min_r   <= sbbs_pkg::RST_MIN_LEVEL;
      max_r   <= sbbs_pkg::RST_MAX_LEVEL;
      rise_r  <= sbbs_pkg::RST_RISE_GAIN;
      fall_r  <= sbbs_pkg::RST_FALL_GAIN;
      decay_r <= sbbs_pkg::RST_PEAK_DECAY;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbbs_pkg::CFG_MIX_CHANNELS:   mix_r   <= cfg_data[0];
        sbbs_pkg::CFG_AVERAGE_LEVELS: avg_r   <= cfg_data[0];
        sbbs_pkg::CFG_MIN_LEVEL:      min_r   <= cfg_data;
        sbbs_pkg::CFG_MAX_LEVEL:      max_r   <= cfg_data;
        sbbs_pkg::CFG_RISE_GAIN:      rise_r  <= cfg_data[GAIN_W-1:0];
        sbbs_pkg::CFG_FALL_GAIN:      fall_r  <= cfg_data[GAIN_W-1:0];
        sbbs_pkg::CFG_PEAK_DECAY:     decay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fold the incoming bin into the accumulators
  always_comb begin
    l_ext   = ACC_W'(in_data.left_mag);
    r_ext   = ACC_W'(in_data.right_mag);
    bins_ok = (bins_r < CNT_W'(MAX_BINS_PER_BAR));
    mix_max = (l_ext > r_ext) ? l_ext : r_ext;
    acc0_f  = acc0_r;
    acc1_f  = acc1_r;
    bins_f  = bins_r;
    if (bins_ok) begin
      bins_f = bins_r + 1'b1;
      if (mix_r) begin
        if (avg_r) begin
          acc0_f = acc0_r + l_ext + r_ext;
        end else begin
          acc0_f = (mix_max > acc0_r) ? mix_max : acc0_r;
        end
      end else begin
        if (avg_r) begin
          acc0_f = acc0_r + l_ext;
          acc1_f = acc1_r + r_ext;
        end else begin
          acc0_f = (l_ext > acc0_r) ? l_ext : acc0_r;
          acc1_f = (r_ext > acc1_r) ? r_ext : acc1_r;
        end
      end
    end
    num0    = acc0_f;
    num1    = mix_r ? '0 : acc1_f;
    divisor = mix_r ? {bins_f, 1'b0} : {1'b0, bins_f};
    bar_ok  = (32'(in_data.bar_number) < 32'(MAX_BARS));
  end

  sbbs_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (divisor),
    .num0    (num0),
    .num1    (num1),
    .done    (div_done),
    .quo0    (quo0),
    .quo1    (quo1)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    acc0_nxt    = acc0_r;
    acc1_nxt    = acc1_r;
    bins_nxt    = bins_r;
    v0_nxt      = v0_r;
    v1_nxt      = v1_r;
    bar_nxt     = bar_r;
    bar_idx_nxt = bar_idx_r;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.last_in_bar) begin
            acc0_nxt    = '0;
            acc1_nxt    = '0;
            bins_nxt    = '0;
            v0_nxt      = num0;
            v1_nxt      = num1;
            bar_nxt     = in_data.bar_number;
            bar_idx_nxt = BAR_AW'(in_data.bar_number);
            if (bar_ok) begin
              if (avg_r) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end else begin
                state_nxt = ST_READ;
              end
            end
          end else begin
            acc0_nxt = acc0_f;
            acc1_nxt = acc1_f;
            bins_nxt = bins_f;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          v0_nxt    = quo0;
          v1_nxt    = quo1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  sbbs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BARS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bar_idx_r),
    .wr_data (row_new),
    .rd_en   (rd_en),
    .rd_addr (bar_idx_r),
    .rd_data (rd_data)
  );

  // Clamp, offset and smoothing product per channel
  always_comb begin
    row_cur   = row_valid_r[bar_idx_r] ? sbbs_pkg::sbbs_entry_t'(rd_data) : '0;
    rise_clip = (rise_r > sbbs_pkg::GAIN_ONE) ? sbbs_pkg::GAIN_ONE : rise_r;
    fall_clip = (fall_r > sbbs_pkg::GAIN_ONE) ? sbbs_pkg::GAIN_ONE : fall_r;
    v_cur[0]  = v0_r;
    v_cur[1]  = v1_r;
    s_cur[0]  = row_cur.level_ch0;
    p_cur[0]  = row_cur.peak_ch0;
    s_cur[1]  = row_cur.level_ch1;
    p_cur[1]  = row_cur.peak_ch1;
    for (int i = 0; i < 2; i++) begin
      v_clamp[i] = (v_cur[i] > ACC_W'(max_r)) ? max_r : v_cur[i][MAG_W-1:0];
      v_lvl[i]   = (v_clamp[i] > min_r) ? (v_clamp[i] - min_r) : '0;
      up_cur[i]  = (v_lvl[i] > s_cur[i]);
      diff[i]    = up_cur[i] ? (v_lvl[i] - s_cur[i]) : (s_cur[i] - v_lvl[i]);
      gain[i]    = up_cur[i] ? rise_clip : fall_clip;
    end
  end

  // Apply the step and the peak hold
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      step[i]  = prod_r[i][GAIN_W-1 +: MAG_W];
      s_new[i] = up_r[i] ? (s_r[i] + step[i]) : (s_r[i] - step[i]);
      if (s_new[i] >= p_r[i]) begin
        p_new[i] = s_new[i];
      end else begin
        p_new[i] = (p_r[i] > decay_r) ? (p_r[i] - decay_r) : '0;
      end
    end
    row_new.level_ch0 = s_new[0];
    row_new.peak_ch0  = p_new[0];
    row_new.level_ch1 = s_new[1];
    row_new.peak_ch1  = p_new[1];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc0_r      <= '0;
      acc1_r      <= '0;
      bins_r      <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc0_r  <= acc0_nxt;
      acc1_r  <= acc1_nxt;
      bins_r  <= bins_nxt;
      if (wr_en) begin
        row_valid_r[bar_idx_r] <= 1'b1;
        out_valid_r            <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    v0_r      <= v0_nxt;
    v1_r      <= v1_nxt;
    bar_r     <= bar_nxt;
    bar_idx_r <= bar_idx_nxt;
    if (state_r == ST_CALC) begin
      for (int i = 0; i < 2; i++) begin
        s_r[i]    <= s_cur[i];
        p_r[i]    <= p_cur[i];
        up_r[i]   <= up_cur[i];
        prod_r[i] <= PROD_W'(diff[i]) * PROD_W'(gain[i]);
      end
    end
    if (wr_en) begin
      out_data_r.bar_out   <= bar_r;
      out_data_r.level_ch0 <= s_new[0];
      out_data_r.peak_ch0  <= p_new[0];
      out_data_r.level_ch1 <= s_new[1];
      out_data_r.peak_ch1  <= p_new[1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/sbbs_ram.sv]
// ----------------------------------------------------------------------------
// sbbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbbs_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/sbbs_div.sv]
// ----------------------------------------------------------------------------
// sbbs_div
// Two-lane restoring divider with a shared divisor. One quotient bit per
// lane per cycle; quotients hold after done until the next start.
// ----------------------------------------------------------------------------
module sbbs_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] divisor,
  input  logic [NUM_W-1:0] num0,
  input  logic [NUM_W-1:0] num1,
  output logic             done,
  output logic [NUM_W-1:0] quo0,
  output logic [NUM_W-1:0] quo1
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r   [2];
  logic [DEN_W-1:0] rem_nxt [2];
  logic [NUM_W-1:0] quo_r   [2];
  logic [NUM_W-1:0] quo_nxt [2];
  logic [DEN_W:0]   shifted [2];
  logic [DEN_W:0]   trial   [2];
  logic             fits    [2];

  // Shift in one numerator bit per lane and try to subtract
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    for (int i = 0; i < 2; i++) begin
      shifted[i] = {rem_r[i], quo_r[i][NUM_W-1]};
      trial[i]   = shifted[i] - {1'b0, den_r};
      fits[i]    = (shifted[i] >= {1'b0, den_r});
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
    end
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = CNT_W'(NUM_W - 1);
      den_nxt    = divisor;
      rem_nxt[0] = '0;
      rem_nxt[1] = '0;
      quo_nxt[0] = num0;
      quo_nxt[1] = num1;
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        rem_nxt[i] = fits[i] ? trial[i][DEN_W-1:0] : shifted[i][DEN_W-1:0];
        quo_nxt[i] = {quo_r[i][NUM_W-2:0], fits[i]};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    den_r    <= den_nxt;
    rem_r[0] <= rem_nxt[0];
    rem_r[1] <= rem_nxt[1];
    quo_r[0] <= quo_nxt[0];
    quo_r[1] <= quo_nxt[1];
  end

  assign done = done_r;
  assign quo0 = quo_r[0];
  assign quo1 = quo_r[1];

endmodule
